>>> hw/rtl/bcm_pkg.sv
// Shared types and constants for the biconnected components block.
// Used by the RAM-based walk sequencer, the result stage and the top level.
// No dependencies.
package bcm_pkg;

	localparam int VERTICES  = 8;
	localparam int VW        = 3;
	localparam int NUM_W     = 4;
	localparam int DEPTH_W   = 4;
	localparam int EDGE_CAP  = VERTICES * (VERTICES - 1) / 2 + 1;
	localparam int SP_W      = 5;
	localparam int FRAME_W   = 2 * VW + 1 + NUM_W;
	localparam int EDGE_W    = 2 * VW;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_RUN   = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_WA,
		ST_ADD_WB,
		ST_ROW,
		ST_SCAN,
		ST_VISITED,
		ST_POP_FRAME,
		ST_POP_LOW,
		ST_COMP_RD,
		ST_COMP_EMIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [VW-1:0]    vert;
		logic [VW-1:0]    par;
		logic             hasp;
		logic [NUM_W-1:0] nxt;
	} frame_t;

	typedef struct packed {
		logic          req;
		logic          fin;
		logic [VW-1:0] from_v;
		logic [VW-1:0] to_v;
		logic          has_edge;
		logic          cend;
	} emit_t;

	function automatic logic [VERTICES-1:0] vbit(input logic [VW-1:0] v);
		logic [VERTICES-1:0] r;
		r = '0;
		r[v] = 1'b1;
		return r;
	endfunction

endpackage

>>> hw/rtl/biconnected_components_matrix.sv
// Top level of the biconnected components block over a bit adjacency matrix.
// Depends on bcm_pkg, bcm_walk (sequencer and memories) and bcm_out.
//
//  Channel  Handshake             Payload
//  in       in_valid / in_stall   operation, vertex_a, vertex_b
//  out      out_valid / out_stall edge_from, edge_to, has_edge, component_end, run_end
//
// An add is a read-modify-write of one or two adjacency rows. The length of a
// run grows with the vertices visited, the already visited neighbours seen, the
// returns to a parent and the edges emitted.
// Reset empties the matrix at once through per-row valid bits.
// A stalled output holds the sequencer at the end of a run, and otherwise only once the hold-back stage is full.
module biconnected_components_matrix (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             operation,
	input  logic [bcm_pkg::VW-1:0] vertex_a,
	input  logic [bcm_pkg::VW-1:0] vertex_b,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [bcm_pkg::VW-1:0] edge_from,
	output logic [bcm_pkg::VW-1:0] edge_to,
	output logic                   has_edge,
	output logic                   component_end,
	output logic                   run_end
);

	bcm_pkg::emit_t em;
	logic           em_rdy;

	bcm_walk u_walk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .vertex_a(vertex_a), .vertex_b(vertex_b),
		.em(em), .em_rdy(em_rdy)
	);

	bcm_out u_out (
		.clk(clk), .arst_n(arst_n),
		.em(em), .em_rdy(em_rdy),
		.out_valid(out_valid), .out_stall(out_stall),
		.edge_from(edge_from), .edge_to(edge_to), .has_edge(has_edge),
		.component_end(component_end), .run_end(run_end)
	);

endmodule

>>> hw/rtl/bcm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is enabled. No dependencies.
module bcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/bcm_walk.sv
// Sequencer for edge insertion, clearing and the depth-first component walk.
// Holds adjacency, discovery, low, edge stack and frame stack in bcm_ram
// instances; depends on bcm_pkg and bcm_ram.
module bcm_walk (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             operation,
	input  logic [bcm_pkg::VW-1:0] vertex_a,
	input  logic [bcm_pkg::VW-1:0] vertex_b,
	output bcm_pkg::emit_t         em,
	input  logic                   em_rdy
);

	localparam int V  = bcm_pkg::VERTICES;
	localparam int VW = bcm_pkg::VW;
	localparam int NW = bcm_pkg::NUM_W;

	bcm_pkg::state_t state_q, state_d;

	logic [VW-1:0]             u_q, par_q, c_q, w_q, a_q, b_q;
	logic                      hasp_q, isp_q, emitted_q;
	logic [NW-1:0]             nxt_q, du_q, lu_q, lc_q, cnt_q;
	logic [bcm_pkg::DEPTH_W-1:0] depth_q, dm1, dm2;
	logic [bcm_pkg::SP_W-1:0]  sp_q, spm1;
	logic [V-1:0]              visited_q, vld_q, row_q;

	// Memory ports.
	logic                      adj_we, adj_re;
	logic [VW-1:0]             adj_wa, adj_ra;
	logic [V-1:0]              adj_wd, adj_rd;
	logic                      dsc_we, dsc_re, low_we, low_re;
	logic [VW-1:0]             dsc_wa, dsc_ra, low_wa, low_ra;
	logic [NW-1:0]             dsc_wd, dsc_rd, low_wd, low_rd;
	logic                      stk_we, stk_re;
	logic [bcm_pkg::SP_W-1:0]  stk_wa, stk_ra;
	logic [bcm_pkg::EDGE_W-1:0] stk_wd, stk_rd;
	logic                      frm_we, frm_re;
	logic [VW-1:0]             frm_wa, frm_ra;
	logic [bcm_pkg::FRAME_W-1:0] frm_wd_v, frm_rd_v;
	bcm_pkg::frame_t           frm_wd, frm_rd;

	// Scan of the cached row.
	logic [V:0]                lowmask;
	logic [V-1:0]              masked;
	logic [VW-1:0]             w_c;
	logic                      found, w_vis, is_par;
	logic [V-1:0]              adj_old;
	logic [VW-1:0]             pop_x, pop_y;
	logic                      pop_last;

	assign dm1  = depth_q - 1'b1;
	assign dm2  = depth_q - 2'd2;
	assign spm1 = sp_q - 1'b1;
	assign adj_old = vld_q[adj_wa] ? adj_rd : '0;
	assign frm_wd_v = frm_wd;
	assign frm_rd   = bcm_pkg::frame_t'(frm_rd_v);
	assign pop_x    = stk_rd[2*VW-1:VW];
	assign pop_y    = stk_rd[VW-1:0];
	assign pop_last = (pop_x == u_q && pop_y == c_q) || sp_q == '0;

	always_comb begin
		lowmask = ({{V{1'b0}}, 1'b1} << nxt_q) - 1'b1;
		masked  = row_q & ~lowmask[V-1:0];
		found   = |masked;
		w_c     = '0;
		for (int i = V - 1; i >= 0; i--) begin
			if (masked[i]) begin
				w_c = VW'(i);
			end
		end
		w_vis  = visited_q[w_c];
		is_par = hasp_q && par_q == w_c;
	end

	assign in_stall = state_q != bcm_pkg::ST_IDLE;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bcm_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (bcm_pkg::op_t'(operation))
						bcm_pkg::OP_ADD: state_d = bcm_pkg::ST_ADD_WA;
						bcm_pkg::OP_RUN: state_d = bcm_pkg::ST_ROW;
						default:         state_d = bcm_pkg::ST_IDLE;
					endcase
				end
			end
			bcm_pkg::ST_ADD_WA:
				state_d = (a_q != b_q) ? bcm_pkg::ST_ADD_WB : bcm_pkg::ST_IDLE;
			bcm_pkg::ST_ADD_WB:    state_d = bcm_pkg::ST_IDLE;
			bcm_pkg::ST_ROW:       state_d = bcm_pkg::ST_SCAN;
			bcm_pkg::ST_SCAN: begin
				if (found) begin
					state_d = w_vis ? bcm_pkg::ST_VISITED : bcm_pkg::ST_ROW;
				end else if (depth_q > 4'd1) begin
					state_d = bcm_pkg::ST_POP_FRAME;
				end else begin
					state_d = bcm_pkg::ST_FINISH;
				end
			end
			bcm_pkg::ST_VISITED:   state_d = bcm_pkg::ST_SCAN;
			bcm_pkg::ST_POP_FRAME: state_d = bcm_pkg::ST_POP_LOW;
			bcm_pkg::ST_POP_LOW:
				state_d = (lc_q >= dsc_rd) ? bcm_pkg::ST_COMP_RD : bcm_pkg::ST_SCAN;
			bcm_pkg::ST_COMP_RD:
				state_d = (sp_q == '0) ? bcm_pkg::ST_SCAN : bcm_pkg::ST_COMP_EMIT;
			bcm_pkg::ST_COMP_EMIT: begin
				if (em_rdy) begin
					state_d = pop_last ? bcm_pkg::ST_SCAN : bcm_pkg::ST_COMP_RD;
				end
			end
			bcm_pkg::ST_FINISH: begin
				if (em_rdy) begin
					state_d = bcm_pkg::ST_IDLE;
				end
			end
			default: state_d = bcm_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and result requests.
	always_comb begin
		adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_re = 1'b0; adj_ra = '0;
		dsc_we = 1'b0; dsc_wa = '0; dsc_wd = '0; dsc_re = 1'b0; dsc_ra = '0;
		low_we = 1'b0; low_wa = '0; low_wd = '0; low_re = 1'b0; low_ra = '0;
		stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_re = 1'b0; stk_ra = '0;
		frm_we = 1'b0; frm_wa = '0; frm_wd = '0; frm_re = 1'b0; frm_ra = '0;
		em = '0;
		case (state_q)
			bcm_pkg::ST_IDLE: begin
				if (in_valid && (bcm_pkg::op_t'(operation) == bcm_pkg::OP_ADD ||
						bcm_pkg::op_t'(operation) == bcm_pkg::OP_RUN)) begin
					adj_re = 1'b1;
					adj_ra = vertex_a;
				end
				if (in_valid && bcm_pkg::op_t'(operation) == bcm_pkg::OP_RUN) begin
					dsc_we = 1'b1; dsc_wa = vertex_a; dsc_wd = '0;
					low_we = 1'b1; low_wa = vertex_a; low_wd = '0;
				end
			end
			bcm_pkg::ST_ADD_WA: begin
				adj_we = 1'b1;
				adj_wa = a_q;
				adj_wd = adj_old | bcm_pkg::vbit(b_q);
				adj_re = a_q != b_q;
				adj_ra = b_q;
			end
			bcm_pkg::ST_ADD_WB: begin
				adj_we = 1'b1;
				adj_wa = b_q;
				adj_wd = adj_old | bcm_pkg::vbit(a_q);
			end
			bcm_pkg::ST_SCAN: begin
				if (found && !w_vis) begin
					dsc_we = 1'b1; dsc_wa = w_c; dsc_wd = cnt_q;
					low_we = 1'b1; low_wa = w_c; low_wd = cnt_q;
					stk_we = 1'b1; stk_wa = sp_q; stk_wd = {u_q, w_c};
					frm_we = 1'b1;
					frm_wa = dm1[VW-1:0];
					frm_wd.vert = u_q;
					frm_wd.par  = par_q;
					frm_wd.hasp = hasp_q;
					frm_wd.nxt  = {1'b0, w_c} + 1'b1;
					adj_re = 1'b1; adj_ra = w_c;
				end else if (found) begin
					dsc_re = 1'b1; dsc_ra = w_c;
				end else if (depth_q > 4'd1) begin
					frm_re = 1'b1; frm_ra = dm2[VW-1:0];
				end
			end
			bcm_pkg::ST_VISITED: begin
				if (!isp_q && dsc_rd < du_q) begin
					stk_we = 1'b1; stk_wa = sp_q; stk_wd = {u_q, w_q};
				end
				if (!isp_q && dsc_rd < lu_q) begin
					low_we = 1'b1; low_wa = u_q; low_wd = dsc_rd;
				end
			end
			bcm_pkg::ST_POP_FRAME: begin
				adj_re = 1'b1; adj_ra = frm_rd.vert;
				dsc_re = 1'b1; dsc_ra = frm_rd.vert;
				low_re = 1'b1; low_ra = frm_rd.vert;
			end
			bcm_pkg::ST_POP_LOW: begin
				if (lc_q < low_rd) begin
					low_we = 1'b1; low_wa = u_q; low_wd = lc_q;
				end
			end
			bcm_pkg::ST_COMP_RD: begin
				stk_re = sp_q != '0;
				stk_ra = spm1;
			end
			bcm_pkg::ST_COMP_EMIT: begin
				em.req      = 1'b1;
				em.from_v   = pop_x;
				em.to_v     = pop_y;
				em.has_edge = 1'b1;
				em.cend     = pop_last;
			end
			bcm_pkg::ST_FINISH: begin
				em.fin = 1'b1;
				em.req = !emitted_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bcm_pkg::ST_IDLE;
			vld_q     <= '0;
			visited_q <= '0;
			cnt_q     <= '0;
			sp_q      <= '0;
			depth_q   <= '0;
			emitted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				bcm_pkg::ST_IDLE: begin
					if (in_valid) begin
						case (bcm_pkg::op_t'(operation))
							bcm_pkg::OP_CLEAR: vld_q <= '0;
							bcm_pkg::OP_RUN: begin
								visited_q <= bcm_pkg::vbit(vertex_a);
								cnt_q     <= 4'd1;
								sp_q      <= '0;
								depth_q   <= 4'd1;
								emitted_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				bcm_pkg::ST_ADD_WA: vld_q[a_q] <= 1'b1;
				bcm_pkg::ST_ADD_WB: vld_q[b_q] <= 1'b1;
				bcm_pkg::ST_SCAN: begin
					if (found && !w_vis) begin
						visited_q[w_c] <= 1'b1;
						cnt_q          <= cnt_q + 1'b1;
						sp_q           <= sp_q + 1'b1;
						depth_q        <= depth_q + 1'b1;
					end else if (!found) begin
						depth_q <= dm1;
					end
				end
				bcm_pkg::ST_VISITED: begin
					if (!isp_q && dsc_rd < du_q) begin
						sp_q <= sp_q + 1'b1;
					end
				end
				bcm_pkg::ST_COMP_RD: begin
					if (sp_q != '0) begin
						sp_q <= spm1;
					end
				end
				bcm_pkg::ST_COMP_EMIT: begin
					if (em_rdy) begin
						emitted_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Cached top frame and operands; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			bcm_pkg::ST_IDLE: begin
				a_q    <= vertex_a;
				b_q    <= vertex_b;
				u_q    <= vertex_a;
				hasp_q <= 1'b0;
				par_q  <= '0;
				nxt_q  <= '0;
				du_q   <= '0;
				lu_q   <= '0;
			end
			bcm_pkg::ST_ROW: row_q <= vld_q[u_q] ? adj_rd : '0;
			bcm_pkg::ST_SCAN: begin
				w_q   <= w_c;
				isp_q <= is_par;
				if (found && !w_vis) begin
					u_q    <= w_c;
					par_q  <= u_q;
					hasp_q <= 1'b1;
					nxt_q  <= '0;
					du_q   <= cnt_q;
					lu_q   <= cnt_q;
				end else if (found) begin
					nxt_q <= {1'b0, w_c} + 1'b1;
				end else begin
					lc_q <= lu_q;
					c_q  <= u_q;
				end
			end
			bcm_pkg::ST_VISITED: begin
				if (!isp_q && dsc_rd < lu_q) begin
					lu_q <= dsc_rd;
				end
			end
			bcm_pkg::ST_POP_FRAME: begin
				u_q    <= frm_rd.vert;
				par_q  <= frm_rd.par;
				hasp_q <= frm_rd.hasp;
				nxt_q  <= frm_rd.nxt;
			end
			bcm_pkg::ST_POP_LOW: begin
				du_q  <= dsc_rd;
				lu_q  <= (lc_q < low_rd) ? lc_q : low_rd;
				row_q <= vld_q[u_q] ? adj_rd : '0;
			end
			default: ;
		endcase
	end

	bcm_ram #(.WIDTH(V), .DEPTH(V), .AW(VW)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
		.re(adj_re), .raddr(adj_ra), .rdata(adj_rd)
	);

	bcm_ram #(.WIDTH(NW), .DEPTH(V), .AW(VW)) u_dsc (
		.clk(clk), .we(dsc_we), .waddr(dsc_wa), .wdata(dsc_wd),
		.re(dsc_re), .raddr(dsc_ra), .rdata(dsc_rd)
	);

	bcm_ram #(.WIDTH(NW), .DEPTH(V), .AW(VW)) u_low (
		.clk(clk), .we(low_we), .waddr(low_wa), .wdata(low_wd),
		.re(low_re), .raddr(low_ra), .rdata(low_rd)
	);

	bcm_ram #(.WIDTH(bcm_pkg::EDGE_W), .DEPTH(bcm_pkg::EDGE_CAP),
			.AW(bcm_pkg::SP_W)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.re(stk_re), .raddr(stk_ra), .rdata(stk_rd)
	);

	bcm_ram #(.WIDTH(bcm_pkg::FRAME_W), .DEPTH(V), .AW(VW)) u_frm (
		.clk(clk), .we(frm_we), .waddr(frm_wa), .wdata(frm_wd_v),
		.re(frm_re), .raddr(frm_ra), .rdata(frm_rd_v)
	);

endmodule

>>> hw/rtl/bcm_out.sv
// Result stage: holds back one result so that the last one of a run can be
// marked, then presents it in an output register. Depends on bcm_pkg.
module bcm_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bcm_pkg::emit_t         em,
	output logic                   em_rdy,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [bcm_pkg::VW-1:0] edge_from,
	output logic [bcm_pkg::VW-1:0] edge_to,
	output logic                   has_edge,
	output logic                   component_end,
	output logic                   run_end
);

	logic                   pend_v_q, out_v_q, out_rdy, take;
	logic [bcm_pkg::VW-1:0] pend_from_q, pend_to_q;
	logic                   pend_he_q, pend_ce_q;

	assign out_rdy   = !out_v_q || !out_stall;
	assign em_rdy    = em.fin ? out_rdy : (!pend_v_q || out_rdy);
	assign take      = (em.req || em.fin) && em_rdy;
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			// A new transaction reaches the output register either at the end of a
			// run or when the held-back one is pushed out by a newer one.
			if (take && (em.fin || pend_v_q)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			if (take) begin
				pend_v_q <= !em.fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (em.fin && em.req) begin
				edge_from     <= em.from_v;
				edge_to       <= em.to_v;
				has_edge      <= em.has_edge;
				component_end <= em.cend;
				run_end       <= 1'b1;
			end else if (em.fin || pend_v_q) begin
				edge_from     <= pend_from_q;
				edge_to       <= pend_to_q;
				has_edge      <= pend_he_q;
				component_end <= pend_ce_q;
				run_end       <= em.fin;
			end
			if (!em.fin) begin
				pend_from_q <= em.from_v;
				pend_to_q   <= em.to_v;
				pend_he_q   <= em.has_edge;
				pend_ce_q   <= em.cend;
			end
		end
	end

endmodule
